// ===== design/text_console_cell_writer_unit_defines.svh =====
// Assertion helpers for the console cell writer design file.
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCCW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tccw_pkg.sv =====
package tccw_pkg;

   // Action codes carried in a request.
   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // Character codes with a meaning of their own.
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   // Attribute after reset and the cell every position holds after reset.
   localparam logic [7:0]  RESET_ATTR = 8'h07;
   localparam logic [15:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] cell_data;
      logic [4:0]  cursor_row_now;
      logic [6:0]  cursor_col_now;
   } rsp_payload_type;

endpackage

// ===== design/tccw_ram.sv =====
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_enable,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_enable) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/text_console_cell_writer_unit.sv =====
// Text console cell writer. The screen is a SCREEN_ROWS x SCREEN_COLS store of 16-bit
// cells (attribute in the high byte, character in the low byte) held in one single-port
// write, single-port read RAM with a registered read, together with a cursor. Every
// request gives exactly one response carrying the cursor after the request and, for a
// read, the addressed cell. Ordinary characters, newline, backspace and out-of-range
// reads are answered straight from the idle state; a character or backspace updates its
// cell with a single RAM write issued in the cycle the request is accepted. A read inside
// the screen presents the address on acceptance and then answers with the registered RAM
// data from S_READ_WAIT. Moving past the last row scrolls the screen, which copies every
// cell one row up at one cell per cycle through the RAM's read and write ports and then
// blanks the bottom row. Clear writes blanks over the whole RAM, one cell per cycle. After
// reset the block writes the reset cell into every entry, and stalls requests until that
// pass is over; attribute writes are taken at any time. The attribute register must only
// be written while no request is in flight.
module text_console_cell_writer_unit #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tccw_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tccw_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [7:0]                csr_write_data
);

   import tccw_pkg::*;
   `include "text_console_cell_writer_unit_defines.svh"

   localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int ROW_W      = $clog2(SCREEN_ROWS);
   localparam int COL_W      = $clog2(SCREEN_COLS);

   localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(SCREEN_COLS);
   localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(CELL_COUNT - SCREEN_COLS);
   localparam logic [ADDR_W-1:0] CELL_LAST   = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(SCREEN_COLS - 1);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ_WAIT,
      S_SCROLL,
      S_FILL
   } state_type;

   // Linear RAM address of a row and column.
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [31:0] row,
                                                   input logic [31:0] col);
      logic [31:0] lin;
      lin = row * SCREEN_COLS + col;
      return lin[ADDR_W-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  cursor_row_ff, cursor_row_in;
   logic [COL_W-1:0]  cursor_col_ff, cursor_col_in;
   logic [7:0]        attr_ff, attr_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [15:0]       ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [15:0]       ram_rdata;

   logic              req_accept;
   logic              rsp_load;
   logic [15:0]       rsp_cell;
   logic [15:0]       blank_cell;
   logic [COL_W:0]    col_inc;
   logic              col_wrap;
   logic              on_last_row;
   logic [ROW_W-1:0]  bs_row;
   logic [COL_W-1:0]  bs_col;
   logic              read_in_range;

   tccw_ram #(
      .WIDTH (16),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock     (clock),
      .wr_enable (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr   (ram_raddr),
      .rd_data   (ram_rdata)
   );

   // A request is taken only when the engine is idle and the response register is
   // either empty or being emptied in this cycle.
   assign req_stall  = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_accept = req_valid && !req_stall;

   assign blank_cell = {attr_ff, CH_SPACE};
   assign attr_in    = csr_write_enable ? csr_write_data : attr_ff;

   // Cursor arithmetic shared by the put and newline paths.
   assign col_inc     = {1'b0, cursor_col_ff} + 1'b1;
   assign col_wrap    = (32'(col_inc) == SCREEN_COLS);
   assign on_last_row = (cursor_row_ff == ROW_LAST);

   // Backspace steps back one cell, wrapping to the end of the row above, and stays at
   // the origin when there is nowhere to go.
   always_comb begin
      bs_row = cursor_row_ff;
      bs_col = cursor_col_ff;
      priority if (cursor_col_ff != '0) begin
         bs_col = cursor_col_ff - 1'b1;
      end else if (cursor_row_ff != '0) begin
         bs_row = cursor_row_ff - 1'b1;
         bs_col = COL_LAST;
      end else begin
         // At the origin the cursor stays where it is.
         bs_row = cursor_row_ff;
         bs_col = cursor_col_ff;
      end
   end

   assign read_in_range = (32'(req_payload.read_row) < SCREEN_ROWS) &&
                          (32'(req_payload.read_col) < SCREEN_COLS);

   always_comb begin
      state_in      = state_ff;
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      idx_in        = idx_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = blank_cell;
      ram_raddr     = idx_ff + ROW_STRIDE;
      rsp_load      = 1'b0;
      rsp_cell      = '0;

      unique case (state_ff)
         S_INIT: begin
            // Reset pass: every entry gets the reset cell, independent of the attribute.
            ram_we    = 1'b1;
            ram_wdata = RESET_CELL;
            if (idx_ff == CELL_LAST) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_accept) begin
               unique case (req_payload.action)
                  ACT_PUT: begin
                     priority if (req_payload.char_code == CH_NEWLINE) begin
                        cursor_col_in = '0;
                        if (on_last_row) begin
                           idx_in   = '0;
                           state_in = S_SCROLL;
                        end else begin
                           cursor_row_in = cursor_row_ff + 1'b1;
                           rsp_load      = 1'b1;
                        end
                     end else if (req_payload.char_code == CH_BACKSPACE) begin
                        ram_we        = 1'b1;
                        ram_waddr     = cell_addr(32'(bs_row), 32'(bs_col));
                        cursor_row_in = bs_row;
                        cursor_col_in = bs_col;
                        rsp_load      = 1'b1;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = cell_addr(32'(cursor_row_ff), 32'(cursor_col_ff));
                        ram_wdata = {attr_ff, req_payload.char_code};
                        if (!col_wrap) begin
                           cursor_col_in = col_inc[COL_W-1:0];
                           rsp_load      = 1'b1;
                        end else if (on_last_row) begin
                           // The cell is written now; the scroll starting next cycle
                           // reads it back and moves it up with the rest of the row.
                           cursor_col_in = '0;
                           idx_in        = '0;
                           state_in      = S_SCROLL;
                        end else begin
                           cursor_col_in = '0;
                           cursor_row_in = cursor_row_ff + 1'b1;
                           rsp_load      = 1'b1;
                        end
                     end
                  end

                  ACT_CLEAR: begin
                     cursor_row_in = '0;
                     cursor_col_in = '0;
                     idx_in        = '0;
                     state_in      = S_FILL;
                  end

                  ACT_READ: begin
                     if (read_in_range) begin
                        ram_raddr = cell_addr(32'(req_payload.read_row),
                                              32'(req_payload.read_col));
                        state_in  = S_READ_WAIT;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end

                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end

         S_READ_WAIT: begin
            rsp_cell = ram_rdata;
            rsp_load = 1'b1;
            state_in = S_IDLE;
         end

         S_SCROLL: begin
            // Cell idx+COLS is read in this cycle and lands one row up in the next, so
            // the writes always trail the reads and never touch a cell still to be read.
            if (idx_ff != '0) begin
               ram_we    = 1'b1;
               ram_waddr = idx_ff - 1'b1;
               ram_wdata = ram_rdata;
            end
            if (idx_ff == SCROLL_LAST) begin
               // idx now points at the first cell of the bottom row.
               state_in = S_FILL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_FILL: begin
            ram_we = 1'b1;
            if (idx_ff == CELL_LAST) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.cell_data      = rsp_cell;
         rsp_data_in.cursor_row_now = 5'(32'(cursor_row_in));
         rsp_data_in.cursor_col_now = 7'(32'(cursor_col_in));
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         attr_ff       <= RESET_ATTR;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         attr_ff       <= attr_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // The cursor never leaves the screen.
   `TCCW_ASSERT_IMPLY(a_cursor_on_screen, clock, reset, 1'b1, (32'(cursor_row_ff) < SCREEN_ROWS) && (32'(cursor_col_ff) < SCREEN_COLS), "cursor outside the screen")
   // A response is only loaded when the previous one has gone or is leaving.
   `TCCW_ASSERT_IMPLY(a_no_overwrite, clock, reset, rsp_load, !rsp_valid_ff || !rsp_stall, "response register overwritten")
   // An in-range read always answers from the wait state: the response is valid and the engine idle after it.
   `TCCW_ASSERT_NEXT(a_read_answers, clock, reset, state_ff == S_READ_WAIT, rsp_valid_ff && (state_ff == S_IDLE), "read did not respond")
   // During a scroll the write trails the read, so no cell is overwritten before it moves.
   `TCCW_ASSERT_IMPLY(a_scroll_order, clock, reset, (state_ff == S_SCROLL) && ram_we, ram_waddr < ram_raddr, "scroll write overtook its read")

endmodule
